// ----- rtl/oled_draw_command_encoder_assert.svh -----
// Assertion macros shared by the encoder's modules.
// Macros expect clk_i in scope; OLED_ASSERT also needs rst_ni.
`ifndef OLED_DRAW_COMMAND_ENCODER_ASSERT_SVH
`define OLED_DRAW_COMMAND_ENCODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define OLED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define OLED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/oled_dce_pkg.sv -----
package oled_dce_pkg;

  // Request kinds on func
  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_LINE  = 2'd1;
  localparam logic [1:0] FUNC_RECT  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Controller command bytes
  localparam logic [7:0] CMD_SET_COL = 8'h15;
  localparam logic [7:0] CMD_SET_ROW = 8'h75;
  localparam logic [7:0] CMD_LINE    = 8'h21;
  localparam logic [7:0] CMD_RECT    = 8'h22;
  localparam logic [7:0] CMD_FILL_EN = 8'h26;
  localparam logic [7:0] FILL_ON     = 8'h01;

  localparam logic [7:0] FIELD_MASK  = 8'h3F;

  // Hold codes on hold_after
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_LINE = 2'd1;
  localparam logic [1:0] HOLD_FILL = 2'd2;

  // Byte counter within one segment
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] PIXEL_LAST_IDX = 4'd7;
  localparam logic [IDX_W-1:0] LINE_LAST_IDX  = 4'd7;
  localparam logic [IDX_W-1:0] FILL_LAST_IDX  = 4'd12;

  // Segment queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    SEG_PIXEL,
    SEG_LINE,
    SEG_FILL
  } seg_kind_e;

  // One hardware drawing operation: a fixed byte run chosen by kind.
  typedef struct packed {
    seg_kind_e   kind;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  a2;
    logic [7:0]  a3;
    logic [15:0] color;
    logic        last;
  } seg_t;

  function automatic logic [IDX_W-1:0] seg_last_idx(seg_kind_e kind);
    logic [IDX_W-1:0] idx;
    case (kind)
      SEG_PIXEL: idx = PIXEL_LAST_IDX;
      SEG_LINE:  idx = LINE_LAST_IDX;
      default:   idx = FILL_LAST_IDX;
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/oled_dce_front.sv -----
`include "oled_draw_command_encoder_assert.svh"

module oled_dce_front #(
  parameter int unsigned PANEL_WIDTH  = 96,
  parameter int unsigned PANEL_HEIGHT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [7:0]          x_start_i,
  input  logic [7:0]          y_start_i,
  input  logic [7:0]          x_end_or_width_i,
  input  logic [7:0]          y_end_or_height_i,
  input  logic [15:0]         color_i,
  output logic                push_o,
  output oled_dce_pkg::seg_t  push_data_o,
  input  logic                q_ready_i
);

  localparam logic [7:0] ColLim = 8'(PANEL_WIDTH);
  localparam logic [7:0] RowLim = 8'(PANEL_HEIGHT);
  localparam logic [7:0] ColMax = 8'(PANEL_WIDTH - 1);
  localparam logic [7:0] RowMax = 8'(PANEL_HEIGHT - 1);

  typedef enum logic [1:0] {
    REQ_PIXEL,
    REQ_LINE,
    REQ_STROKE,
    REQ_FILL
  } req_kind_e;

  function automatic logic line_ok(logic [7:0] x0, logic [7:0] y0,
                                   logic [7:0] x1, logic [7:0] y1);
    return !((y0 >= RowLim) && (y1 >= RowLim)) && !((x0 >= ColLim) && (x1 >= ColLim));
  endfunction

  function automatic logic [7:0] clamp_col(logic [7:0] v);
    return (v >= ColLim) ? ColMax : v;
  endfunction

  function automatic logic [7:0] clamp_row(logic [7:0] v);
    return (v >= RowLim) ? RowMax : v;
  endfunction

  logic        draw_mode_q;
  logic [3:0]  mask_q, mask_d, mask_rest;
  req_kind_e   kind_q, kind_d;
  logic [7:0]  p0_q, p0_d, p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic [15:0] color_q, color_d;

  logic        accept, in_panel;
  logic [8:0]  x_sum, y_sum;
  logic [7:0]  w_clip, h_clip, x_excl, y_excl;
  logic [1:0]  sel;
  logic [7:0]  lx0, ly0, lx1, ly1;

  assign mask_rest  = mask_q & (mask_q - 4'd1);
  assign push_o     = (mask_q != 4'd0) && q_ready_i;
  assign in_stall_o = !((mask_q == 4'd0) || (push_o && (mask_rest == 4'd0)));
  assign accept     = in_valid_i && !in_stall_o;

  // Clip the rectangle size to the panel edge
  always_comb begin
    x_sum    = {1'b0, x_start_i} + {1'b0, x_end_or_width_i};
    y_sum    = {1'b0, y_start_i} + {1'b0, y_end_or_height_i};
    w_clip   = (x_sum > {1'b0, ColLim}) ? ColLim - x_start_i : x_end_or_width_i;
    h_clip   = (y_sum > {1'b0, RowLim}) ? RowLim - y_start_i : y_end_or_height_i;
    x_excl   = x_start_i + w_clip;
    y_excl   = y_start_i + h_clip;
    in_panel = (x_start_i < ColLim) && (y_start_i < RowLim);
  end

  // Classify the request into zero to four segments
  always_comb begin
    kind_d  = kind_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    p3_d    = p3_q;
    color_d = color_q;
    mask_d  = mask_q;
    if (accept) begin
      p0_d    = x_start_i;
      p1_d    = y_start_i;
      p2_d    = x_end_or_width_i;
      p3_d    = y_end_or_height_i;
      color_d = color_i;
      case (func_i)
        oled_dce_pkg::FUNC_PIXEL: begin
          kind_d = REQ_PIXEL;
          mask_d = {3'b000, in_panel};
        end
        oled_dce_pkg::FUNC_LINE: begin
          kind_d = REQ_LINE;
          mask_d = {3'b000, line_ok(x_start_i, y_start_i, x_end_or_width_i,
                                    y_end_or_height_i)};
        end
        oled_dce_pkg::FUNC_RECT: begin
          if (draw_mode_q) begin
            kind_d = REQ_FILL;
            p2_d   = x_excl - 8'd1;
            p3_d   = y_excl - 8'd1;
            mask_d = {3'b000, in_panel};
          end else begin
            // Edges: top, left, right, bottom from bit 0 upward
            kind_d = REQ_STROKE;
            p2_d   = x_excl;
            p3_d   = y_excl;
            mask_d = in_panel ? {line_ok(x_start_i, y_excl, x_excl, y_excl),
                                 line_ok(x_excl, y_start_i, x_excl, y_excl),
                                 line_ok(x_start_i, y_start_i, x_start_i, y_excl),
                                 line_ok(x_start_i, y_start_i, x_excl, y_start_i)}
                              : 4'd0;
          end
        end
        default: begin
          kind_d = REQ_FILL;
          p0_d   = 8'd0;
          p1_d   = 8'd0;
          p2_d   = ColMax;
          p3_d   = RowMax;
          mask_d = 4'b0001;
        end
      endcase
    end else if (push_o) begin
      mask_d = mask_rest;
    end
  end

  // Build the segment for the lowest pending bit
  always_comb begin
    if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end

    case (sel)
      2'd0: begin
        lx0 = p0_q; ly0 = p1_q; lx1 = p2_q; ly1 = p1_q;
      end
      2'd1: begin
        lx0 = p0_q; ly0 = p1_q; lx1 = p0_q; ly1 = p3_q;
      end
      2'd2: begin
        lx0 = p2_q; ly0 = p1_q; lx1 = p2_q; ly1 = p3_q;
      end
      default: begin
        lx0 = p0_q; ly0 = p3_q; lx1 = p2_q; ly1 = p3_q;
      end
    endcase
    if (kind_q == REQ_LINE) begin
      lx0 = p0_q; ly0 = p1_q; lx1 = p2_q; ly1 = p3_q;
    end

    push_data_o.color = color_q;
    push_data_o.last  = (mask_rest == 4'd0);
    case (kind_q)
      REQ_PIXEL: begin
        push_data_o.kind = oled_dce_pkg::SEG_PIXEL;
        push_data_o.a0   = p0_q;
        push_data_o.a1   = p1_q;
        push_data_o.a2   = p2_q;
        push_data_o.a3   = p3_q;
      end
      REQ_LINE, REQ_STROKE: begin
        push_data_o.kind = oled_dce_pkg::SEG_LINE;
        push_data_o.a0   = clamp_col(lx0);
        push_data_o.a1   = clamp_row(ly0);
        push_data_o.a2   = clamp_col(lx1);
        push_data_o.a3   = clamp_row(ly1);
      end
      default: begin
        push_data_o.kind = oled_dce_pkg::SEG_FILL;
        push_data_o.a0   = p0_q;
        push_data_o.a1   = p1_q;
        push_data_o.a2   = p2_q;
        push_data_o.a3   = p3_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_mode_q <= 1'b0;
      mask_q      <= 4'd0;
      kind_q      <= REQ_PIXEL;
    end else begin
      if (cfg_we_i) begin
        draw_mode_q <= cfg_wdata_i;
      end
      mask_q <= mask_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    p3_q    <= p3_d;
    color_q <= color_d;
  end

  `OLED_ASSERT(a_front_single_seg, ((mask_q != 4'd0) && (kind_q != REQ_STROKE)) |-> (mask_rest == 4'd0), "front: non-stroke request holds more than one segment")
  `OLED_ASSERT(a_front_drain, (push_o && (mask_rest != 4'd0)) |=> (mask_q != 4'd0), "front: pending edges lost")

endmodule

// ----- rtl/oled_dce_queue.sv -----
`include "oled_draw_command_encoder_assert.svh"

module oled_dce_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  oled_dce_pkg::seg_t  push_data_i,
  output logic                ready_o,
  output logic                valid_o,
  output oled_dce_pkg::seg_t  data_o,
  input  logic                pop_i
);

  localparam logic [oled_dce_pkg::QUEUE_CNT_W-1:0] Full =
    oled_dce_pkg::QUEUE_CNT_W'(oled_dce_pkg::QUEUE_DEPTH);

  oled_dce_pkg::seg_t                    mem_q [oled_dce_pkg::QUEUE_DEPTH];
  logic [oled_dce_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [oled_dce_pkg::QUEUE_CNT_W-1:0]  count_q, count_d;
  logic                                  do_push, do_pop;

  assign ready_o = (count_q != Full);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `OLED_ASSERT(a_queue_count, count_q <= Full, "queue: count beyond depth")
  `OLED_ASSERT(a_queue_no_overrun, !(push_i && !ready_o), "queue: push while full")

endmodule

// ----- rtl/oled_dce_back.sv -----
`include "oled_draw_command_encoder_assert.svh"

module oled_dce_back #(
  parameter int unsigned PANEL_WIDTH  = 96,
  parameter int unsigned PANEL_HEIGHT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  oled_dce_pkg::seg_t  q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                is_data_o,
  output logic [1:0]          hold_after_o,
  output logic                last_o
);

  localparam logic [7:0] ColMax = 8'(PANEL_WIDTH - 1);
  localparam logic [7:0] RowMax = 8'(PANEL_HEIGHT - 1);

  oled_dce_pkg::seg_t                cur_q, cur_d;
  logic                              cur_valid_q, cur_valid_d;
  logic [oled_dce_pkg::IDX_W-1:0]    idx_q, idx_d;

  logic                              out_valid_q, out_valid_d;
  logic [7:0]                        out_byte_q, out_byte_d;
  logic                              is_data_q, is_data_d;
  logic [1:0]                        hold_q, hold_d;
  logic                              last_q, last_d;

  logic                              advance, at_end;
  logic [7:0]                        red, green, blue;
  logic [7:0]                        beat_byte;
  logic                              beat_data;
  logic [1:0]                        beat_hold;

  assign advance = !out_valid_q || !out_stall_i;
  assign at_end  = (idx_q == oled_dce_pkg::seg_last_idx(cur_q.kind));
  assign pop_o   = q_valid_i && (!cur_valid_q || (advance && at_end));

  // Expand RGB565 into three 6-bit fields
  assign red   = {2'b00, cur_q.color[15:11], 1'b0};
  assign green = {2'b00, cur_q.color[10:5]} & oled_dce_pkg::FIELD_MASK;
  assign blue  = {2'b00, cur_q.color[4:0], 1'b0};

  always_comb begin
    beat_data = 1'b0;
    beat_hold = oled_dce_pkg::HOLD_NONE;
    case (cur_q.kind)
      oled_dce_pkg::SEG_PIXEL: begin
        case (idx_q)
          4'd0: beat_byte = oled_dce_pkg::CMD_SET_COL;
          4'd1: beat_byte = cur_q.a0;
          4'd2: beat_byte = ColMax;
          4'd3: beat_byte = oled_dce_pkg::CMD_SET_ROW;
          4'd4: beat_byte = cur_q.a1;
          4'd5: beat_byte = RowMax;
          4'd6: begin
            beat_byte = cur_q.color[15:8];
            beat_data = 1'b1;
          end
          default: begin
            beat_byte = cur_q.color[7:0];
            beat_data = 1'b1;
          end
        endcase
      end
      oled_dce_pkg::SEG_LINE: begin
        case (idx_q)
          4'd0: beat_byte = oled_dce_pkg::CMD_LINE;
          4'd1: beat_byte = cur_q.a0;
          4'd2: beat_byte = cur_q.a1;
          4'd3: beat_byte = cur_q.a2;
          4'd4: begin
            beat_byte = cur_q.a3;
            beat_hold = oled_dce_pkg::HOLD_LINE;
          end
          4'd5: beat_byte = red;
          4'd6: beat_byte = green;
          default: begin
            beat_byte = blue;
            beat_hold = oled_dce_pkg::HOLD_LINE;
          end
        endcase
      end
      default: begin
        case (idx_q)
          4'd0:  beat_byte = oled_dce_pkg::CMD_FILL_EN;
          4'd1:  beat_byte = oled_dce_pkg::FILL_ON;
          4'd2:  beat_byte = oled_dce_pkg::CMD_RECT;
          4'd3:  beat_byte = cur_q.a0;
          4'd4:  beat_byte = cur_q.a1;
          4'd5:  beat_byte = cur_q.a2;
          4'd6:  beat_byte = cur_q.a3;
          4'd7:  beat_byte = red;
          4'd8:  beat_byte = green;
          4'd9:  beat_byte = blue;
          4'd10: beat_byte = red;
          4'd11: beat_byte = green;
          default: begin
            beat_byte = blue;
            beat_hold = oled_dce_pkg::HOLD_FILL;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    is_data_d   = is_data_q;
    hold_d      = hold_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = cur_valid_q;
      if (cur_valid_q) begin
        out_byte_d = beat_byte;
        is_data_d  = beat_data;
        hold_d     = beat_hold;
        last_d     = cur_q.last && at_end;
        idx_d      = idx_q + 1'b1;
        if (at_end) begin
          cur_valid_d = 1'b0;
        end
      end
    end
    if (pop_o) begin
      cur_d       = q_data_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    is_data_q  <= is_data_d;
    hold_q     <= hold_d;
    last_q     <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_data_o    = is_data_q;
  assign hold_after_o = hold_q;
  assign last_o       = last_q;

  `OLED_ASSERT(a_back_idx_range, cur_valid_q |-> (idx_q <= oled_dce_pkg::seg_last_idx(cur_q.kind)), "back: byte index past segment end")
  `OLED_ASSERT(a_back_emit, (advance && cur_valid_q) |=> out_valid_q, "back: beat dropped")
  `OLED_ASSERT(a_back_pop_valid, pop_o |-> q_valid_i, "back: pop from empty queue")

endmodule

// ----- rtl/oled_draw_command_encoder.sv -----
// Draw command encoder: turns one draw request (pixel, line, rectangle or
// clear) into the panel controller's byte run, one byte per output beat,
// each tagged command or data, with a settle hint and a last flag on the
// final byte of the run. A request that lands fully off the panel produces
// no beats. The front accepts a request and splits it into drawing
// segments, one per cycle while the queue has room, into a two-entry
// queue; a stroked rectangle makes up to four line segments, every other
// request at most one. The back plays out a segment at one byte per cycle
// while the byte channel is not stalled: 8 beats for a pixel or line, 13
// for a filled rectangle or clear, up to 32 for a stroked rectangle.
// Sustained rate is therefore set by the back's single byte output, and
// the next request is taken while the previous one is still being sent,
// so runs follow each other without gaps. in_stall_o rises only while the
// queue is full or a stroked rectangle still has edges to hand over.
// draw_mode (cfg_wdata_i under cfg_we_i) picks outline (0) or solid
// fill (1) for rectangles; write it only when the block is idle.
module oled_draw_command_encoder #(
  parameter int unsigned PANEL_WIDTH  = 96,
  parameter int unsigned PANEL_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  x_start_i,
  input  logic [7:0]  y_start_i,
  input  logic [7:0]  x_end_or_width_i,
  input  logic [7:0]  y_end_or_height_i,
  input  logic [15:0] color_i,
  // byte channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_data_o,
  output logic [1:0]  hold_after_o,
  output logic        last_o
);

  // segment handoff between front and queue
  logic               push;
  oled_dce_pkg::seg_t push_data;
  logic               q_ready;

  // queue head toward the back
  logic               q_valid;
  oled_dce_pkg::seg_t q_data;
  logic               pop;

  // Classify requests, clip coordinates, split stroked rectangles
  oled_dce_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .x_start_i         (x_start_i),
    .y_start_i         (y_start_i),
    .x_end_or_width_i  (x_end_or_width_i),
    .y_end_or_height_i (y_end_or_height_i),
    .color_i           (color_i),
    .push_o            (push),
    .push_data_o       (push_data),
    .q_ready_i         (q_ready)
  );

  // Decouple front from back so each can stall on its own
  oled_dce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (pop)
  );

  // Sequence each segment into controller bytes, one beat per cycle while the byte channel is not stalled
  oled_dce_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_data_o    (is_data_o),
    .hold_after_o (hold_after_o),
    .last_o       (last_o)
  );

endmodule

// ----- tb/oled_byte_run_checker.sv -----
`timescale 1ns / 1ps
module oled_byte_run_checker #(
  parameter int unsigned PANEL_WIDTH  = 96,
  parameter int unsigned PANEL_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  x_start_i,
  input  logic [7:0]  y_start_i,
  input  logic [7:0]  x_end_or_width_i,
  input  logic [7:0]  y_end_or_height_i,
  input  logic [15:0] color_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        is_data_i,
  input  logic [1:0]  hold_after_i,
  input  logic        last_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);

  typedef struct packed {
    logic [7:0] val;
    logic       is_data;
    logic [1:0] hold;
    logic       last;
  } panel_beat_t;

  panel_beat_t byte_run_q[$];
  panel_beat_t req_run_q[$];
  panel_beat_t want_beat;
  logic        fill_mode_q;
  int unsigned mismatches;

  function automatic void put_beat(input logic [7:0] b, input logic d, input logic [1:0] h);
    panel_beat_t beat;
    beat.val     = b;
    beat.is_data = d;
    beat.hold    = h;
    beat.last    = 1'b0;
    req_run_q.push_back(beat);
  endfunction

  // RGB565 goes out as three 6-bit fields: red and blue doubled.
  function automatic void put_color(input logic [15:0] color, input logic [1:0] hold_last);
    put_beat({2'b00, color[15:11], 1'b0}, 1'b0, oled_dce_pkg::HOLD_NONE);
    put_beat(8'(color >> 5) & oled_dce_pkg::FIELD_MASK, 1'b0, oled_dce_pkg::HOLD_NONE);
    put_beat({2'b00, color[4:0], 1'b0}, 1'b0, hold_last);
  endfunction

  function automatic void encode_line(input int unsigned x0, input int unsigned y0,
                                      input int unsigned x1, input int unsigned y1,
                                      input logic [15:0] color);
    if (y0 >= PANEL_HEIGHT && y1 >= PANEL_HEIGHT) return;
    if (x0 >= PANEL_WIDTH && x1 >= PANEL_WIDTH) return;
    if (x0 >= PANEL_WIDTH) x0 = PANEL_WIDTH - 1;
    if (y0 >= PANEL_HEIGHT) y0 = PANEL_HEIGHT - 1;
    if (x1 >= PANEL_WIDTH) x1 = PANEL_WIDTH - 1;
    if (y1 >= PANEL_HEIGHT) y1 = PANEL_HEIGHT - 1;
    put_beat(oled_dce_pkg::CMD_LINE, 1'b0, oled_dce_pkg::HOLD_NONE);
    put_beat(8'(x0), 1'b0, oled_dce_pkg::HOLD_NONE);
    put_beat(8'(y0), 1'b0, oled_dce_pkg::HOLD_NONE);
    put_beat(8'(x1), 1'b0, oled_dce_pkg::HOLD_NONE);
    put_beat(8'(y1), 1'b0, oled_dce_pkg::HOLD_LINE);
    put_color(color, oled_dce_pkg::HOLD_LINE);
  endfunction

  function automatic void encode_rect(input int unsigned x, input int unsigned y,
                                      input int unsigned w, input int unsigned h,
                                      input logic [15:0] color, input logic fill);
    int unsigned xe;
    int unsigned ye;
    if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
    if (y + h > PANEL_HEIGHT) h = PANEL_HEIGHT - y;
    if (x + w > PANEL_WIDTH) w = PANEL_WIDTH - x;
    if (!fill) begin
      xe = (x + w) & 8'hFF;
      ye = (y + h) & 8'hFF;
      encode_line(x, y, xe, y, color);
      encode_line(x, y, x, ye, color);
      encode_line(xe, y, xe, ye, color);
      encode_line(x, ye, xe, ye, color);
    end else begin
      put_beat(oled_dce_pkg::CMD_FILL_EN, 1'b0, oled_dce_pkg::HOLD_NONE);
      put_beat(oled_dce_pkg::FILL_ON, 1'b0, oled_dce_pkg::HOLD_NONE);
      put_beat(oled_dce_pkg::CMD_RECT, 1'b0, oled_dce_pkg::HOLD_NONE);
      put_beat(8'(x), 1'b0, oled_dce_pkg::HOLD_NONE);
      put_beat(8'(y), 1'b0, oled_dce_pkg::HOLD_NONE);
      // zero size wraps the end corner
      put_beat(8'(x + w - 1), 1'b0, oled_dce_pkg::HOLD_NONE);
      put_beat(8'(y + h - 1), 1'b0, oled_dce_pkg::HOLD_NONE);
      put_color(color, oled_dce_pkg::HOLD_NONE);
      put_color(color, oled_dce_pkg::HOLD_FILL);
    end
  endfunction

  function automatic void encode_request(input logic [1:0] fn, input logic [7:0] xs,
                                         input logic [7:0] ys, input logic [7:0] xw,
                                         input logic [7:0] yh, input logic [15:0] color);
    panel_beat_t beat;
    req_run_q.delete();
    case (fn)
      oled_dce_pkg::FUNC_PIXEL: begin
        if (xs < PANEL_WIDTH && ys < PANEL_HEIGHT) begin
          put_beat(oled_dce_pkg::CMD_SET_COL, 1'b0, oled_dce_pkg::HOLD_NONE);
          put_beat(xs, 1'b0, oled_dce_pkg::HOLD_NONE);
          put_beat(8'(PANEL_WIDTH - 1), 1'b0, oled_dce_pkg::HOLD_NONE);
          put_beat(oled_dce_pkg::CMD_SET_ROW, 1'b0, oled_dce_pkg::HOLD_NONE);
          put_beat(ys, 1'b0, oled_dce_pkg::HOLD_NONE);
          put_beat(8'(PANEL_HEIGHT - 1), 1'b0, oled_dce_pkg::HOLD_NONE);
          put_beat(color[15:8], 1'b1, oled_dce_pkg::HOLD_NONE);
          put_beat(color[7:0], 1'b1, oled_dce_pkg::HOLD_NONE);
        end
      end
      oled_dce_pkg::FUNC_LINE: encode_line(32'(xs), 32'(ys), 32'(xw), 32'(yh), color);
      oled_dce_pkg::FUNC_RECT: encode_rect(32'(xs), 32'(ys), 32'(xw), 32'(yh), color,
                                           fill_mode_q);
      default:   encode_rect(0, 0, PANEL_WIDTH, PANEL_HEIGHT, color, 1'b1);
    endcase
    foreach (req_run_q[i]) begin
      beat      = req_run_q[i];
      beat.last = (i == req_run_q.size() - 1);
      byte_run_q.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_mode_q = 1'b0;
      mismatches  = 0;
      byte_run_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) fill_mode_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        encode_request(func_i, x_start_i, y_start_i, x_end_or_width_i,
                       y_end_or_height_i, color_i);
      if (out_valid_i && !out_stall_i) begin
        if (byte_run_q.size() == 0) begin
          mismatches += 1;
          $display("%0t: unexpected beat: expected none, got byte %h data %b hold %0d last %b",
                   $time, out_byte_i, is_data_i, hold_after_i, last_i);
        end else begin
          want_beat = byte_run_q.pop_front();
          if (out_byte_i !== want_beat.val || is_data_i !== want_beat.is_data ||
              hold_after_i !== want_beat.hold || last_i !== want_beat.last) begin
            mismatches += 1;
            $display("%0t: beat mismatch: expected byte %h data %b hold %0d last %b,",
                     $time, want_beat.val, want_beat.is_data, want_beat.hold,
                     want_beat.last, " got byte %h data %b hold %0d last %b",
                     out_byte_i, is_data_i, hold_after_i, last_i);
          end
        end
      end
      pending_o        <= byte_run_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned PANEL_W          = 96;
  localparam int unsigned PANEL_H          = 64;
  // Cycles to let the block finish a request that yields no beats.
  localparam int unsigned SETTLE_CYCLES    = 40;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT      = 3000;
  localparam int unsigned RANDOM_PER_PHASE = 84;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic        cfg_wdata_i       = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic [1:0]  func_i            = oled_dce_pkg::FUNC_PIXEL;
  logic [7:0]  x_start_i         = 8'h00;
  logic [7:0]  y_start_i         = 8'h00;
  logic [7:0]  x_end_or_width_i  = 8'h00;
  logic [7:0]  y_end_or_height_i = 8'h00;
  logic [15:0] color_i           = 16'h0000;
  logic        out_stall_i       = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        is_data_o;
  logic [1:0]  hold_after_o;
  logic        last_o;

  int unsigned pending_beats;
  int unsigned mismatch_count;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  always #1 clk_i = ~clk_i;

  oled_draw_command_encoder #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .x_start_i        (x_start_i),
    .y_start_i        (y_start_i),
    .x_end_or_width_i (x_end_or_width_i),
    .y_end_or_height_i(y_end_or_height_i),
    .color_i          (color_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .is_data_o        (is_data_o),
    .hold_after_o     (hold_after_o),
    .last_o           (last_o)
  );

  oled_byte_run_checker #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .x_start_i        (x_start_i),
    .y_start_i        (y_start_i),
    .x_end_or_width_i (x_end_or_width_i),
    .y_end_or_height_i(y_end_or_height_i),
    .color_i          (color_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_i       (out_byte_o),
    .is_data_i        (is_data_o),
    .hold_after_i     (hold_after_o),
    .last_i           (last_o),
    .pending_o        (pending_beats),
    .mismatch_count_o (mismatch_count)
  );

  // Stall the byte channel at random; a zero rate gives a clean stream.
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Random idle
  // cycles go in front, so gaps land at every point of the byte run.
  task automatic send_request(input logic [1:0] fn, input logic [7:0] xs,
                              input logic [7:0] ys, input logic [7:0] xw,
                              input logic [7:0] yh, input logic [15:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    func_i            <= fn;
    x_start_i         <= xs;
    y_start_i         <= ys;
    x_end_or_width_i  <= xw;
    y_end_or_height_i <= yh;
    color_i           <= color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid, wait until every predicted beat has come out, then give an
  // off-panel request still in flight time to retire.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write draw_mode; only called with the block idle.
  task automatic write_mode(input logic fill);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fill;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly on-panel geometry so runs actually get drawn; the rest spans
  // the full field range to hit the clipping and drop paths and every bit.
  task automatic send_random_request();
    logic [1:0]  fn;
    logic [7:0]  xs;
    logic [7:0]  ys;
    logic [7:0]  xw;
    logic [7:0]  yh;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25)      fn = oled_dce_pkg::FUNC_PIXEL;
    else if (pick < 55) fn = oled_dce_pkg::FUNC_LINE;
    else if (pick < 92) fn = oled_dce_pkg::FUNC_RECT;
    else                fn = oled_dce_pkg::FUNC_CLEAR;
    if ($urandom_range(99) < 75) begin
      xs = 8'($urandom_range(PANEL_W - 1));
      ys = 8'($urandom_range(PANEL_H - 1));
      if (fn == oled_dce_pkg::FUNC_LINE) begin
        xw = 8'($urandom_range(PANEL_W + 15));
        yh = 8'($urandom_range(PANEL_H + 15));
      end else begin
        xw = 8'($urandom_range(PANEL_W / 2));
        yh = 8'($urandom_range(PANEL_H / 2));
      end
    end else begin
      xs = 8'($urandom_range(255));
      ys = 8'($urandom_range(255));
      xw = 8'($urandom_range(255));
      yh = 8'($urandom_range(255));
    end
    send_request(fn, xs, ys, xw, yh, 16'($urandom()));
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input logic fill, input logic mid_pause);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_mode(fill);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      // Hold off the sender once until the byte stream runs dry.
      if (mid_pause && i == RANDOM_PER_PHASE / 2) wait_drained();
      send_random_request();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 21;
    recv_stall_pct = 49;

    // Outline mode: pixels at the panel corners and just off it.
    write_mode(1'b0);
    send_request(oled_dce_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    send_request(oled_dce_pkg::FUNC_PIXEL, 8'd95, 8'd63, 8'd255, 8'd255, 16'hFFFF);
    send_request(oled_dce_pkg::FUNC_PIXEL, 8'd96, 8'd10, 8'd3, 8'd4, 16'h1234);
    send_request(oled_dce_pkg::FUNC_PIXEL, 8'd10, 8'd64, 8'd3, 8'd4, 16'h4321);
    send_request(oled_dce_pkg::FUNC_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 16'hA5C3);
    // Lines: full diagonal, both ends off one axis, clamped ends.
    send_request(oled_dce_pkg::FUNC_LINE, 8'd0, 8'd0, 8'd95, 8'd63, 16'hF800);
    send_request(oled_dce_pkg::FUNC_LINE, 8'd100, 8'd5, 8'd200, 8'd40, 16'h07E0);
    send_request(oled_dce_pkg::FUNC_LINE, 8'd5, 8'd70, 8'd40, 8'd255, 16'h001F);
    send_request(oled_dce_pkg::FUNC_LINE, 8'd200, 8'd10, 8'd20, 8'd100, 16'h07E0);
    send_request(oled_dce_pkg::FUNC_LINE, 8'd255, 8'd255, 8'd0, 8'd0, 16'h5A5A);
    // Stroked rectangles: plain, oversized, corner off, zero size.
    send_request(oled_dce_pkg::FUNC_RECT, 8'd10, 8'd10, 8'd20, 8'd15, 16'h001F);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd90, 8'd60, 8'd255, 8'd255, 16'h1234);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd96, 8'd0, 8'd5, 8'd5, 16'hFFFF);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd0, 8'd64, 8'd5, 8'd5, 16'hFFFF);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd5, 8'd5, 8'd0, 8'd0, 16'hC0DE);
    // Clear ignores the mode and the geometry fields.
    send_request(oled_dce_pkg::FUNC_CLEAR, 8'd77, 8'd200, 8'd13, 8'd255, 16'hFFFF);
    wait_drained();

    // Fill mode: full panel, zero size wrap, oversized, corner off.
    write_mode(1'b1);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd0, 8'd0, 8'd96, 8'd64, 16'h8410);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd0, 8'd0, 8'd0, 8'd0, 16'h7BEF);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd95, 8'd63, 8'd255, 8'd255, 16'hFFFF);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd255, 8'd0, 8'd4, 8'd4, 16'h0000);
    send_request(oled_dce_pkg::FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    send_request(oled_dce_pkg::FUNC_RECT, 8'd30, 8'd20, 8'd1, 8'd1, 16'h5AA5);
    wait_drained();

    // Random traffic under three idling profiles, mode changed between.
    run_random_phase(21, 49, 1'b0, 1'b1);
    run_random_phase(49, 21, 1'b1, 1'b0);
    run_random_phase(0, 0, 1'($urandom_range(1)), 1'b0);

    if (mismatch_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
